@@ sv/ffs_pkg.sv @@
package ffs_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_CHECK     = 2'd0,
        KIND_ARM       = 2'd1,
        KIND_EMERGENCY = 2'd2,
        KIND_RESET     = 2'd3
    } t_kind;

    // failsafe states
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_WARNING   = 2'd1,
        ST_LANDING   = 2'd2,
        ST_EMERGENCY = 2'd3
    } t_fs_state;

    // fault reasons
    localparam logic [2:0] RSN_NONE   = 3'd0;
    localparam logic [2:0] RSN_SIGNAL = 3'd1;
    localparam logic [2:0] RSN_TILT   = 3'd2;
    localparam logic [2:0] RSN_SENSOR = 3'd3;
    localparam logic [2:0] RSN_ARM_TO = 3'd4;
    localparam logic [2:0] RSN_KILL   = 3'd5;

    // arm refusal codes
    localparam logic [2:0] REF_NONE      = 3'd0;
    localparam logic [2:0] REF_IMU       = 3'd1;
    localparam logic [2:0] REF_DRIVER    = 3'd2;
    localparam logic [2:0] REF_NO_LINK   = 3'd3;
    localparam logic [2:0] REF_THROTTLE  = 3'd4;
    localparam logic [2:0] REF_TILT      = 3'd5;
    localparam logic [2:0] REF_EMERGENCY = 3'd6;

    // register indexes
    localparam logic [1:0] CFG_MAX_TILT        = 2'd0;
    localparam logic [1:0] CFG_SIGNAL_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_LANDING_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_IDLE_DISARM     = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [10:0] MAX_TILT_RST        = 11'd550;
    localparam logic [15:0] SIGNAL_TIMEOUT_RST  = 16'd1000;
    localparam logic [15:0] LANDING_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] IDLE_DISARM_RST     = 16'd15000;

    // fixed limits, tenths of a degree and tenths of a percent
    localparam logic [11:0] ARM_TILT_LIMIT     = 12'd300;
    localparam logic [9:0]  ARM_THROTTLE_LIMIT = 10'd10;
    localparam logic [9:0]  IDLE_THROTTLE      = 10'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        now_ms;
        logic               motors_armed;
        logic               motors_healthy;
        logic               link_connected;
        logic               imu_healthy;
        logic signed [11:0] roll;
        logic signed [11:0] pitch;
        logic [9:0]         throttle;
        logic [31:0]        signal_age_ms;
        logic [2:0]         emergency_code;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] reported_state;
        logic [2:0] fault_reason;
        logic       arm_allowed;
        logic [2:0] arm_refusal;
        logic       emergency_stop;
        logic       disarm_request;
    } t_out_beat;

    typedef struct packed {
        logic [10:0] max_tilt;
        logic [15:0] signal_timeout_ms;
        logic [15:0] landing_timeout_ms;
        logic [15:0] idle_disarm_ms;
    } t_cfg;

    typedef struct packed {
        t_fs_state   fs_state;
        logic [2:0]  fault_code;
        logic [31:0] arm_time;
        logic [31:0] landing_start;
    } t_state;

    // magnitude of a 12 bit signed angle, -2048 gives 2048 as unsigned
    function automatic logic [11:0] abs12(input logic signed [11:0] v);
        logic [11:0] r;
        r = v[11] ? (~v + 12'd1) : v;
        return r;
    endfunction

endpackage

@@ sv/ffs_cfg.sv @@
module ffs_cfg
    import ffs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_tilt           <= MAX_TILT_RST;
            r_cfg.signal_timeout_ms  <= SIGNAL_TIMEOUT_RST;
            r_cfg.landing_timeout_ms <= LANDING_TIMEOUT_RST;
            r_cfg.idle_disarm_ms     <= IDLE_DISARM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_TILT:        r_cfg.max_tilt           <= i_cfg_wdata[10:0];
                CFG_SIGNAL_TIMEOUT:  r_cfg.signal_timeout_ms  <= i_cfg_wdata;
                CFG_LANDING_TIMEOUT: r_cfg.landing_timeout_ms <= i_cfg_wdata;
                CFG_IDLE_DISARM:     r_cfg.idle_disarm_ms     <= i_cfg_wdata;
                default:             r_cfg                    <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/ffs_eval.sv @@
module ffs_eval
    import ffs_pkg::*;
(
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    output t_state    o_state,
    output t_out_beat o_result
);

    logic [11:0] aroll;
    logic [11:0] apitch;
    logic        tilt_over;
    logic        arm_tilt_over;
    logic        link_lost;
    logic [31:0] landing_age;
    logic [31:0] idle_age;
    logic        enter_landing;

    always_comb begin
        aroll         = abs12(i_beat.roll);
        apitch        = abs12(i_beat.pitch);
        tilt_over     = (aroll > {1'b0, i_cfg.max_tilt}) || (apitch > {1'b0, i_cfg.max_tilt});
        arm_tilt_over = (aroll > ARM_TILT_LIMIT) || (apitch > ARM_TILT_LIMIT);
        link_lost     = i_beat.signal_age_ms > {16'd0, i_cfg.signal_timeout_ms};
        landing_age   = i_beat.now_ms - i_state.landing_start;
        idle_age      = i_beat.now_ms - i_state.arm_time;
        enter_landing = (i_state.fs_state != ST_LANDING) && (i_state.fs_state != ST_EMERGENCY);
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;

        unique case (t_kind'(i_beat.kind))
            KIND_CHECK: begin
                priority if (!i_beat.motors_armed) begin
                    if (i_state.fs_state != ST_EMERGENCY) begin
                        o_state.fs_state   = ST_OK;
                        o_state.fault_code = RSN_NONE;
                    end
                end else if (tilt_over) begin
                    o_state.fs_state        = ST_EMERGENCY;
                    o_state.fault_code      = RSN_TILT;
                    o_result.emergency_stop = 1'b1;
                end else if (!i_beat.imu_healthy) begin
                    o_state.fs_state        = ST_EMERGENCY;
                    o_state.fault_code      = RSN_SENSOR;
                    o_result.emergency_stop = 1'b1;
                end else if (link_lost) begin
                    // a fresh landing starts now, so its age is zero
                    if (enter_landing) begin
                        o_state.fs_state      = ST_LANDING;
                        o_state.fault_code    = RSN_SIGNAL;
                        o_state.landing_start = i_beat.now_ms;
                    end else if (landing_age > {16'd0, i_cfg.landing_timeout_ms}) begin
                        o_state.fs_state        = ST_EMERGENCY;
                        o_result.emergency_stop = 1'b1;
                    end
                end else if (i_beat.throttle <= IDLE_THROTTLE &&
                             idle_age > {16'd0, i_cfg.idle_disarm_ms}) begin
                    o_result.disarm_request = 1'b1;
                    o_state.fault_code      = RSN_ARM_TO;
                end else begin
                    if (i_beat.throttle > IDLE_THROTTLE) begin
                        o_state.arm_time = i_beat.now_ms;
                    end
                    if (i_state.fs_state == ST_LANDING || i_state.fs_state == ST_WARNING) begin
                        o_state.fs_state   = ST_OK;
                        o_state.fault_code = RSN_NONE;
                    end
                end
            end
            KIND_ARM: begin
                priority if (!i_beat.imu_healthy) begin
                    o_result.arm_refusal = REF_IMU;
                end else if (!i_beat.motors_healthy) begin
                    o_result.arm_refusal = REF_DRIVER;
                end else if (!i_beat.link_connected) begin
                    o_result.arm_refusal = REF_NO_LINK;
                end else if (i_beat.throttle > ARM_THROTTLE_LIMIT) begin
                    o_result.arm_refusal = REF_THROTTLE;
                end else if (arm_tilt_over) begin
                    o_result.arm_refusal = REF_TILT;
                end else if (i_state.fs_state == ST_EMERGENCY) begin
                    o_result.arm_refusal = REF_EMERGENCY;
                end else begin
                    o_result.arm_allowed = 1'b1;
                    o_state.arm_time     = i_beat.now_ms;
                end
            end
            KIND_EMERGENCY: begin
                o_state.fs_state        = ST_EMERGENCY;
                o_state.fault_code      = (i_beat.emergency_code > RSN_KILL) ?
                                          RSN_KILL : i_beat.emergency_code;
                o_result.emergency_stop = 1'b1;
            end
            KIND_RESET: begin
                o_state.fs_state      = ST_OK;
                o_state.fault_code    = RSN_NONE;
                o_state.landing_start = '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase

        // idle disarm reports ok whatever the held state
        o_result.reported_state = o_result.disarm_request ? ST_OK : o_state.fs_state;
        o_result.fault_reason   = o_state.fault_code;
    end

endmodule

@@ sv/flight_failsafe_supervisor_unit.sv @@
// flow: an accepted beat waits in the input stage, is evaluated and moves into the result stage
// when the result slot is empty or being drained; throughput is one beat per cycle unless
// i_out_ready stalls it, set by the single evaluation stage that also writes the state
// reset: synchronous active low i_rst_n clears both pipeline valids, returns the failsafe
// state to ok with no fault, zeroes arm and landing times and loads the register defaults
module flight_failsafe_supervisor_unit
    import ffs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat
);

    t_cfg      cfg;
    t_state    n_state;
    t_out_beat result;

    // input stage
    logic      r_in_vld;
    logic      n_in_vld;
    t_in_beat  r_in_beat;

    // result stage
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_beat r_out_beat;

    // supervisor state, written when a beat moves into the result stage
    t_state    r_state;

    logic      in_acc;
    logic      adv;

    ffs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ffs_eval u_eval (
        .i_beat   (r_in_beat),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (result)
    );

    // the held beat advances when the result slot is empty or being drained
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld  = in_acc ? 1'b1 : (adv ? 1'b0 : r_in_vld);
        n_out_vld = adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld              <= 1'b0;
            r_out_vld             <= 1'b0;
            r_state.fs_state      <= ST_OK;
            r_state.fault_code    <= RSN_NONE;
            r_state.arm_time      <= '0;
            r_state.landing_start <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_beat <= i_in_beat;
        end
        if (adv) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule

@@ sv/ffs_checker.sv @@
module ffs_checker
    import ffs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_beat             o_out_beat
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("result beat dropped or changed while stalled");

    // a motor cut always reports emergency
    a_stop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.emergency_stop) |->
            (o_out_beat.reported_state == ST_EMERGENCY && !o_out_beat.disarm_request))
        else $error("stop pulse without emergency state");

    // idle disarm reports ok with the arm timeout reason
    a_disarm_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.disarm_request) |->
            (o_out_beat.reported_state == ST_OK && o_out_beat.fault_reason == RSN_ARM_TO))
        else $error("disarm pulse with wrong state or reason");

    // a granted arm carries no refusal, no stop pulse and no emergency state
    a_arm_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.arm_allowed) |->
            (o_out_beat.arm_refusal == REF_NONE && !o_out_beat.emergency_stop &&
             o_out_beat.reported_state != ST_EMERGENCY))
        else $error("arm granted with refusal, pulse or emergency");

endmodule

bind flight_failsafe_supervisor_unit ffs_checker u_ffs_checker (.*);
